>>> hdl/etbm_pkg.sv
package etbm_pkg;

  localparam int BLK_W  = 24;
  localparam int LEN_W  = 8;
  localparam int WORD_W = 32;
  localparam int SLOT_W = 4;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_LOAD   = 2'd2;

  localparam logic [LEN_W-1:0] MAX_RUN = 8'd255;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [BLK_W-1:0]  logical_block;
    logic [BLK_W-1:0]  new_block;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] slot_word;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  physical_block;
    logic [SLOT_W-1:0] used_slot;
    logic [WORD_W-1:0] slot_after;
  } out_item_t;

endpackage

>>> hdl/etbm_in_if.sv
interface etbm_in_if;
  logic               valid;
  logic               ready;
  etbm_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> hdl/etbm_out_if.sv
interface etbm_out_if;
  logic                valid;
  logic                ready;
  etbm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

>>> hdl/extent_table_block_mapper.sv
// Extent table block mapper. The block holds SLOT_COUNT extent words (start block in bits
// 31:8, run length in bits 7:0), cleared at reset; the first zero word ends the list. Each
// item is a lookup, an append, a slot load or an unknown action and yields exactly one
// result item. A single slot read port, compare and add unit steps through the table one
// slot per cycle. A lookup or append that ends at slot k registers its result when the scan
// reaches slot k and the output register is free, and the input becomes ready again as the
// result is registered. A load or an unknown action finishes in its first scan step. The
// input is not ready while an item is in progress, and a finished item waits in place while
// the previous result has not yet been taken. The result sits in an output register, so a
// new item can be accepted while an earlier result still waits to be taken.
module extent_table_block_mapper #(
  parameter int SLOT_COUNT = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  etbm_in_if.sink             in_ch,
  etbm_out_if.source          out_ch
);

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int BASE_W = $clog2(SLOT_COUNT * 255 + 1);
  localparam int BW     = etbm_pkg::BLK_W;
  localparam int LW     = etbm_pkg::LEN_W;
  localparam int WW     = etbm_pkg::WORD_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  etbm_pkg::in_item_t  req_r;
  logic                out_valid_r, out_valid_nxt;
  etbm_pkg::out_item_t out_item_r, out_item_nxt;
  logic [WW-1:0]       table_r [SLOT_COUNT];

  logic                out_free;
  logic                finish;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [WW-1:0]       wr_word;
  logic [WW-1:0]       cur_word;
  logic [LW-1:0]       cur_len;
  logic [BW-1:0]       cur_start;
  logic [BW:0]         run_end;
  logic [BW:0]         base_end;
  logic [BW-1:0]       offset;
  logic                at_end;

  assign out_free = !out_valid_r || out_ch.ready;
  assign at_end   = (cnt_r == CNT_W'(SLOT_COUNT));
  assign cur_word = at_end ? '0 : table_r[IDX_W'(cnt_r)];
  assign cur_len  = cur_word[LW-1:0];
  assign cur_start = cur_word[WW-1:LW];
  assign run_end  = {1'b0, cur_start} + (BW+1)'(cur_len);
  assign base_end = (BW+1)'(base_r) + (BW+1)'(cur_len);
  assign offset   = req_r.logical_block - BW'(base_r);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    base_nxt     = base_r;
    finish       = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = IDX_W'(cnt_r);
    wr_word      = '0;
    out_item_nxt = '{status: etbm_pkg::ST_ERROR, physical_block: '0, used_slot: '0,
                     slot_after: '0};
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt  = '0;
        base_nxt = '0;
        if (in_ch.valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        unique case (req_r.action)
          etbm_pkg::ACT_LOOKUP: begin
            if (at_end || cur_word == '0) begin
              finish = 1'b1;
            end else if ({1'b0, req_r.logical_block} < base_end) begin
              finish = 1'b1;
              out_item_nxt.status         = etbm_pkg::ST_OK;
              out_item_nxt.physical_block = cur_start + offset;
              out_item_nxt.used_slot      = etbm_pkg::SLOT_W'(cnt_r);
              out_item_nxt.slot_after     = cur_word;
            end else begin
              cnt_nxt  = cnt_r + 1'b1;
              base_nxt = BASE_W'(base_end);
            end
          end
          etbm_pkg::ACT_APPEND: begin
            if (at_end) begin
              finish = 1'b1;
            end else if (cur_word == '0) begin
              finish  = 1'b1;
              wr_en   = 1'b1;
              wr_word = {req_r.new_block, LW'(1)};
              out_item_nxt.status         = etbm_pkg::ST_OK;
              out_item_nxt.physical_block = req_r.new_block;
              out_item_nxt.used_slot      = etbm_pkg::SLOT_W'(cnt_r);
              out_item_nxt.slot_after     = wr_word;
            end else if (cur_len < etbm_pkg::MAX_RUN && run_end == {1'b0, req_r.new_block}) begin
              finish  = 1'b1;
              wr_en   = 1'b1;
              wr_word = cur_word + WW'(1);
              out_item_nxt.status         = etbm_pkg::ST_OK;
              out_item_nxt.physical_block = run_end[BW-1:0];
              out_item_nxt.used_slot      = etbm_pkg::SLOT_W'(cnt_r);
              out_item_nxt.slot_after     = wr_word;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          etbm_pkg::ACT_LOAD: begin
            finish = 1'b1;
            if (int'(req_r.slot_index) < SLOT_COUNT) begin
              wr_en   = 1'b1;
              wr_idx  = IDX_W'(req_r.slot_index);
              wr_word = req_r.slot_word;
              out_item_nxt.status     = etbm_pkg::ST_OK;
              out_item_nxt.used_slot  = req_r.slot_index;
              out_item_nxt.slot_after = req_r.slot_word;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          if (out_free) begin
            state_nxt = S_IDLE;
          end else begin
            wr_en    = 1'b0;
            cnt_nxt  = cnt_r;
            base_nxt = base_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (finish && out_free) ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        table_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        table_r[wr_idx] <= wr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r <= in_ch.item;
    end
    if (finish && out_free) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.item  = out_item_r;

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_SCAN))
    else $error("accepted item did not start a table scan");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(SLOT_COUNT)))
    else $error("slot counter ran past the table");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.item.status == etbm_pkg::ST_ERROR) |->
      (out_ch.item.physical_block == '0 && out_ch.item.used_slot == '0 &&
       out_ch.item.slot_after == '0))
    else $error("error result carries nonzero fields");

endmodule

>>> dv/block_map_checker.sv
`timescale 1ns / 1ps

module block_map_checker #(
  parameter int SLOT_COUNT = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  etbm_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  etbm_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  checked_count
);

  logic [etbm_pkg::WORD_W-1:0] extent_words [SLOT_COUNT];
  etbm_pkg::out_item_t         expected_maps [$];
  etbm_pkg::out_item_t         want;

  initial begin
    fail_count = 0;
    pending_count = 0;
    checked_count = 0;
  end

  task automatic predict_mapping(input etbm_pkg::in_item_t it,
                                 output etbm_pkg::out_item_t res);
    logic [31:0] base;
    logic [31:0] run_len;
    logic [31:0] run_start;
    logic [31:0] word;
    logic [31:0] sum;
    int          k;
    int          free_slot;
    bit          done;
    bit          ended;
    res = '0;
    res.status = etbm_pkg::ST_ERROR;
    done = 1'b0;
    ended = 1'b0;
    free_slot = -1;
    base = '0;
    case (it.action)
      etbm_pkg::ACT_LOOKUP: begin
        for (k = 0; k < SLOT_COUNT; k++) begin
          word = extent_words[k];
          if (!done && !ended) begin
            if (word == '0) begin
              ended = 1'b1;
            end else begin
              run_len = {24'd0, word[7:0]};
              run_start = {8'd0, word[31:8]};
              if ({8'd0, it.logical_block} < base + run_len) begin
                sum = run_start + ({8'd0, it.logical_block} - base);
                res.status = etbm_pkg::ST_OK;
                res.physical_block = sum[etbm_pkg::BLK_W-1:0];
                res.used_slot = k[etbm_pkg::SLOT_W-1:0];
                res.slot_after = word;
                done = 1'b1;
              end
              base = base + run_len;
            end
          end
        end
      end
      etbm_pkg::ACT_APPEND: begin
        for (k = 0; k < SLOT_COUNT; k++) begin
          word = extent_words[k];
          if (!done && !ended) begin
            if (word == '0) begin
              ended = 1'b1;
              free_slot = k;
            end else begin
              run_len = {24'd0, word[7:0]};
              run_start = {8'd0, word[31:8]};
              sum = run_start + run_len;
              if (word[7:0] < etbm_pkg::MAX_RUN && sum == {8'd0, it.new_block}) begin
                extent_words[k] = word + 32'd1;
                res.status = etbm_pkg::ST_OK;
                res.physical_block = sum[etbm_pkg::BLK_W-1:0];
                res.used_slot = k[etbm_pkg::SLOT_W-1:0];
                res.slot_after = extent_words[k];
                done = 1'b1;
              end
            end
          end
        end
        if (!done && free_slot >= 0) begin
          extent_words[free_slot] = {it.new_block, 8'd1};
          res.status = etbm_pkg::ST_OK;
          res.physical_block = it.new_block;
          res.used_slot = free_slot[etbm_pkg::SLOT_W-1:0];
          res.slot_after = extent_words[free_slot];
        end
      end
      etbm_pkg::ACT_LOAD: begin
        if (it.slot_index < SLOT_COUNT) begin
          extent_words[it.slot_index] = it.slot_word;
          res.status = etbm_pkg::ST_OK;
          res.used_slot = it.slot_index;
          res.slot_after = it.slot_word;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (extent_words[k]) extent_words[k] = '0;
      expected_maps.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_mapping(in_item, want);
        expected_maps.push_back(want);
      end
      if (out_valid && out_ready) begin
        checked_count++;
        if (expected_maps.size() == 0) begin
          $display("%0t: result item with nothing expected: %h", $time, out_item);
          fail_count++;
        end else begin
          want = expected_maps.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_item.status);
            fail_count++;
          end
          if (out_item.physical_block !== want.physical_block) begin
            $display("%0t: physical_block expected %h, got %h", $time,
                     want.physical_block, out_item.physical_block);
            fail_count++;
          end
          if (out_item.used_slot !== want.used_slot) begin
            $display("%0t: used_slot expected %0d, got %0d", $time, want.used_slot,
                     out_item.used_slot);
            fail_count++;
          end
          if (out_item.slot_after !== want.slot_after) begin
            $display("%0t: slot_after expected %h, got %h", $time, want.slot_after,
                     out_item.slot_after);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_maps.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = 10;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 2 * (SLOTS + 2);
  localparam int BLK_W = etbm_pkg::BLK_W;
  localparam int SLOT_W = etbm_pkg::SLOT_W;
  localparam int WORD_W = etbm_pkg::WORD_W;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  etbm_in_if  in_ch ();
  etbm_out_if out_ch ();

  int fail_count;
  int pending_count;
  int checked_count;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit hold_req = 1'b0;
  int n_items = 0;
  int n_lookup = 0;
  int n_append = 0;
  int n_load = 0;
  int n_bad = 0;
  int quiet_cycles;
  logic [BLK_W-1:0] next_blk = '0;

  always #10 clk = ~clk;

  extent_table_block_mapper #(
    .SLOT_COUNT(SLOTS)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  block_map_checker #(
    .SLOT_COUNT(SLOTS)
  ) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_item      (in_ch.item),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_item     (out_ch.item),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .checked_count(checked_count)
  );

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No handshake for %0d cycles, %0d results outstanding", quiet_cycles,
                 pending_count);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [BLK_W-1:0] lblk,
                           input logic [BLK_W-1:0] nblk, input logic [SLOT_W-1:0] idx,
                           input logic [WORD_W-1:0] word);
    etbm_pkg::in_item_t it;
    it.action = act;
    it.logical_block = lblk;
    it.new_block = nblk;
    it.slot_index = idx;
    it.slot_word = word;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    n_items++;
    case (act)
      etbm_pkg::ACT_LOOKUP: n_lookup++;
      etbm_pkg::ACT_APPEND: n_append++;
      etbm_pkg::ACT_LOAD:   n_load++;
      default:              n_bad++;
    endcase
  endtask

  task automatic lookup_blk(input logic [BLK_W-1:0] lblk);
    send_item(etbm_pkg::ACT_LOOKUP, lblk, 24'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic append_blk(input logic [BLK_W-1:0] nblk);
    send_item(etbm_pkg::ACT_APPEND, 24'($urandom), nblk, 4'($urandom), $urandom);
  endtask

  task automatic load_slot(input logic [SLOT_W-1:0] idx, input logic [WORD_W-1:0] word);
    send_item(etbm_pkg::ACT_LOAD, 24'($urandom), 24'($urandom), idx, word);
  endtask

  function automatic logic [BLK_W-1:0] pick_block();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) begin
      pick_block = 24'($urandom_range(4095));
    end else if (sel < 60) begin
      pick_block = 24'hFFFFFF - 24'($urandom_range(300));
    end else begin
      pick_block = 24'($urandom);
    end
  endfunction

  task automatic random_step();
    int               r;
    int               sel;
    logic [BLK_W-1:0] start;
    logic [7:0]       len;
    logic [SLOT_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 4) begin
      for (int k = 0; k < SLOTS; k++) load_slot(k[SLOT_W-1:0], '0);
      next_blk = pick_block();
    end else if (r < 34) begin
      if ($urandom_range(99) < 15) next_blk = pick_block();
      append_blk(next_blk);
      next_blk = next_blk + 24'd1;
    end else if (r < 74) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        lookup_blk(24'($urandom_range(600)));
      end else if (sel < 85) begin
        lookup_blk(24'($urandom_range(3000)));
      end else begin
        lookup_blk(24'($urandom));
      end
    end else if (r < 92) begin
      idx = ($urandom_range(99) < 90) ? 4'($urandom_range(9)) : 4'($urandom_range(15, 10));
      start = pick_block();
      sel = $urandom_range(9);
      case (sel)
        1:       len = 8'hFF;
        2:       len = 8'h00;
        3, 4:    len = 8'($urandom_range(254, 250));
        default: len = 8'($urandom_range(40, 1));
      endcase
      if (sel == 0) begin
        load_slot(idx, '0);
      end else begin
        load_slot(idx, {start, len});
        if ($urandom_range(99) < 30) next_blk = start + {16'd0, len};
      end
    end else begin
      send_item(ACT_UNKNOWN, 24'($urandom), 24'($urandom), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    hold_done = 1'b0;
    drain_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 37;
    rcv_idle_pct = 55;

    lookup_blk(24'd0);
    lookup_blk(24'hFFFFFF);
    append_blk(24'd0);
    lookup_blk(24'd0);
    append_blk(24'd1);
    load_slot(4'd1, {24'hFFFFF0, 8'h20});
    lookup_blk(24'd33);
    load_slot(4'd2, {24'h000100, 8'h00});
    load_slot(4'd3, {24'h000200, 8'h05});
    lookup_blk(24'd34);
    append_blk(24'h000010);
    load_slot(4'd5, {24'h000300, 8'hFF});
    append_blk(24'h0003FF);
    append_blk(24'h000400);
    load_slot(4'd10, $urandom);
    load_slot(4'd15, $urandom);
    send_item(ACT_UNKNOWN, 24'hFFFFFF, 24'hFFFFFF, 4'hF, 32'hFFFFFFFF);
    load_slot(4'd7, 32'hFFFFFFFF);
    load_slot(4'd8, {24'h123456, 8'h01});
    load_slot(4'd9, 32'h00000080);
    append_blk(24'hABCDEF);
    lookup_blk(24'hFFFFFF);
    load_slot(4'd3, '0);
    lookup_blk(24'd34);
    append_blk(24'd2);

    while (n_items < 570) begin
      if (!hold_done && n_items >= 300) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      random_step();
    end

    snd_idle_pct = 55;
    rcv_idle_pct = 37;
    while (n_items < 1110) begin
      if (!drain_done && n_items >= 850) begin
        in_ch.valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
        drain_done = 1'b1;
      end
      random_step();
    end

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (n_items < 1650) random_step();

    in_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d lookups, %0d appends, %0d loads, %0d unknown actions.",
             n_items, n_lookup, n_append, n_load, n_bad);
    $display("Compared %0d results across three idle mixes, a long output stall and a drain.",
             checked_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
